// ----- design/word_frequency_counter_defines.svh -----
// Assertion macros for the word frequency counter.
// Depends on nothing; included by modules that assert.
`ifndef WORD_FREQUENCY_COUNTER_DEFINES_SVH
`define WORD_FREQUENCY_COUNTER_DEFINES_SVH
// implication checked on every clock unless reset is active
`define WFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define WFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/wfc_pkg.sv -----
// Shared types and constants for the word frequency counter.
// No dependencies.
package wfc_pkg;
    localparam int TABLE_DEPTH_DEF  = 1024;
    localparam int MAX_WORD_LEN_DEF = 63;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_FINISH = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_byte;
    } in_word_t;

    typedef struct packed {
        logic [9:0]  word_index;
        logic [23:0] word_count;
        logic        new_word;
        logic        dropped;
        logic [5:0]  word_length;
        logic [10:0] distinct_words;
        logic        finished;
    } out_word_t;

    // front-to-back command
    typedef struct packed {
        logic       is_clear;
        logic       has_word;
        logic       finished;
        logic [5:0] length;
    } cmd_t;

    function automatic logic splits_words(input logic [7:0] b);
        splits_words = (b == 8'h00) || (b >= 8'h09 && b <= 8'h0D) ||
            (b >= 8'h20 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
            (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
    endfunction
endpackage

// ----- design/wfc_front.sv -----
// Front end: tokenizes bytes, builds words, issues commands with word text.
// Depends on wfc_pkg.
module wfc_front #(
    parameter int MAX_WORD_LEN = wfc_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wfc_pkg::in_word_t             in_data,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output wfc_pkg::cmd_t                 cmd,
    output logic [MAX_WORD_LEN-1:0][7:0]  cmd_chars
);
    logic [MAX_WORD_LEN-1:0][7:0] pend_reg, pend_next;
    logic [5:0] plen_reg, plen_next;
    logic       cv_reg, cv_next;
    wfc_pkg::cmd_t cmd_reg, cmd_next;
    logic [MAX_WORD_LEN-1:0][7:0] cch_reg, cch_next;
    logic [7:0] lc;
    logic       take;

    assign in_ready  = !cv_reg || cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = cv_reg;
    assign cmd       = cmd_reg;
    assign cmd_chars = cch_reg;
    assign lc = (in_data.char_byte >= 8'h41 && in_data.char_byte <= 8'h5A) ?
                in_data.char_byte + 8'h20 : in_data.char_byte;

    always_comb
    begin
        pend_next = pend_reg;
        plen_next = plen_reg;
        cv_next   = cv_reg && !cmd_ready;
        cmd_next  = cmd_reg;
        cch_next  = cch_reg;
        if (take)
        begin
            cmd_next = '0;
            cch_next = pend_reg;
            cmd_next.length = plen_reg;
            case (in_data.req_type)
                wfc_pkg::REQ_BYTE:
                begin
                    if (wfc_pkg::splits_words(in_data.char_byte))
                    begin
                        if (plen_reg != 6'd0)
                        begin
                            cv_next = 1'b1;
                            cmd_next.has_word = 1'b1;
                            plen_next = '0;
                        end
                    end
                    else
                    begin
                        pend_next[plen_reg[$clog2(MAX_WORD_LEN+1)-1:0]] = lc;
                        cch_next = pend_next;
                        if (plen_reg + 6'd1 >= 6'(MAX_WORD_LEN))
                        begin
                            cv_next = 1'b1;
                            cmd_next.has_word = 1'b1;
                            cmd_next.length = plen_reg + 6'd1;
                            plen_next = '0;
                        end
                        else
                            plen_next = plen_reg + 6'd1;
                    end
                end
                wfc_pkg::REQ_FINISH:
                begin
                    cv_next = 1'b1;
                    cmd_next.finished = 1'b1;
                    cmd_next.has_word = plen_reg != 6'd0;
                    plen_next = '0;
                end
                wfc_pkg::REQ_CLEAR:
                begin
                    cv_next = 1'b1;
                    cmd_next.is_clear = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            cv_reg   <= 1'b0;
            cmd_reg  <= '0;
        end
        else
        begin
            plen_reg <= plen_next;
            cv_reg   <= cv_next;
            cmd_reg  <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        cch_reg  <= cch_next;
    end
endmodule

// ----- design/wfc_back.sv -----
// Back end: sequential table search, count update, append; result register.
// Depends on wfc_pkg and the defines header.
`include "word_frequency_counter_defines.svh"
module wfc_back #(
    parameter int TABLE_DEPTH  = wfc_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_WORD_LEN = wfc_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [10:0]                   table_limit,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  wfc_pkg::cmd_t                 cmd,
    input  logic [MAX_WORD_LEN-1:0][7:0]  cmd_chars,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wfc_pkg::out_word_t            out_data
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = MAX_WORD_LEN * 8 + 6;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_UPD, S_OUT} state_t;

    logic [EW-1:0] text_mem [TABLE_DEPTH];
    logic [23:0]   cnt_mem  [TABLE_DEPTH];

    state_t state_reg, state_next;
    logic [UW-1:0] used_reg, used_next;
    logic [UW-1:0] k_reg, k_next;
    logic [EW-1:0] key_reg, key_next;
    wfc_pkg::cmd_t c_reg, c_next;
    wfc_pkg::out_word_t res_reg, res_next;
    logic [EW-1:0] rd_text_reg;
    logic [23:0]   rd_cnt_reg;
    logic          ov_reg, ov_next;
    wfc_pkg::out_word_t od_reg, od_next;
    logic [UW-1:0] lim;
    logic          hit;
    logic [23:0]   inc;

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign lim = (table_limit > 11'(TABLE_DEPTH)) ? UW'(TABLE_DEPTH) : UW'(table_limit);
    assign hit = (rd_text_reg == key_reg);
    assign inc = (rd_cnt_reg == wfc_pkg::COUNT_MAX) ? rd_cnt_reg : rd_cnt_reg + 24'd1;

    always_ff @(posedge clk)
    begin
        rd_text_reg <= text_mem[k_reg[AW-1:0]];
        rd_cnt_reg  <= cnt_mem[k_reg[AW-1:0]];
        if (state_reg == S_CMP && k_reg < used_reg && hit)
            cnt_mem[k_reg[AW-1:0]] <= inc;
        else if (state_reg == S_CMP && k_reg >= used_reg && used_reg < lim)
        begin
            text_mem[used_reg[AW-1:0]] <= key_reg;
            cnt_mem[used_reg[AW-1:0]]  <= 24'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        k_next     = k_reg;
        key_next   = key_reg;
        c_next     = c_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (cmd_valid)
                begin
                    c_next = cmd;
                    k_next = '0;
                    for (int i = 0; i < MAX_WORD_LEN; i++)
                        key_next[i*8 +: 8] = (i < int'(cmd.length)) ? cmd_chars[i] : 8'h00;
                    key_next[EW-1 -: 6] = cmd.length;
                    if (cmd.is_clear)
                        used_next = '0;
                    else if (!cmd.has_word)
                    begin
                        res_next = '0;
                        res_next.finished = 1'b1;
                        res_next.distinct_words = 11'(used_reg);
                        state_next = S_OUT;
                    end
                    else
                        state_next = (used_reg == '0) ? S_CMP : S_READ;
                end
            S_READ:
                state_next = S_CMP;
            S_CMP:
            begin
                res_next = '0;
                res_next.word_length = c_reg.length;
                res_next.finished = c_reg.finished;
                if (k_reg < used_reg && hit)
                begin
                    res_next.word_index = 10'(k_reg);
                    res_next.word_count = inc;
                    res_next.distinct_words = 11'(used_reg);
                    state_next = S_OUT;
                end
                else if (k_reg + UW'(1) < used_reg)
                begin
                    k_next = k_reg + UW'(1);
                    state_next = S_UPD;
                end
                else if (k_reg + UW'(1) == used_reg && k_reg < used_reg)
                begin
                    k_next = used_reg;
                    state_next = S_CMP;
                end
                else if (used_reg < lim)
                begin
                    res_next.word_index = 10'(used_reg);
                    res_next.word_count = 24'd1;
                    res_next.new_word = 1'b1;
                    res_next.distinct_words = 11'(used_reg + UW'(1));
                    used_next = used_reg + UW'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    res_next.dropped = 1'b1;
                    res_next.distinct_words = 11'(used_reg);
                    state_next = S_OUT;
                end
            end
            S_UPD:
                state_next = S_CMP;
            S_OUT:
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next = res_reg;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
            key_reg   <= '0;
            c_reg     <= '0;
            res_reg   <= '0;
            od_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
            key_reg   <= key_next;
            c_reg     <= c_next;
            res_reg   <= res_next;
            od_reg    <= od_next;
        end
    end

    `WFC_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_reg <= UW'(TABLE_DEPTH))
    `WFC_ASSERT_NXT(a_out_hold, clk, rst_n, ov_reg && !out_ready, ov_reg && $stable(od_reg))
    `WFC_ASSERT_IMP(a_flag_excl, clk, rst_n, ov_reg, !(od_reg.new_word && od_reg.dropped))
endmodule

// ----- design/word_frequency_counter.sv -----
// Word frequency counter: tokenizing front end, table-searching back end.
// Depends on wfc_pkg, wfc_front, wfc_back.
// Each finished word scans the stored words one entry at a time (memory
// read, then compare), so its cost grows with the N distinct words stored;
// bytes that do not end a word need no table search.
// A one-entry command register decouples the two halves.
module word_frequency_counter #(
    parameter int TABLE_DEPTH  = wfc_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_WORD_LEN = wfc_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  wfc_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wfc_pkg::out_word_t  out_data
);
    logic [10:0] limit_reg;
    logic cmd_valid, cmd_ready;
    wfc_pkg::cmd_t cmd;
    logic [MAX_WORD_LEN-1:0][7:0] cmd_chars;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 11'd1024;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    wfc_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_data,
        .cmd_valid, .cmd_ready, .cmd, .cmd_chars
    );

    wfc_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_WORD_LEN(MAX_WORD_LEN)) u_back (
        .clk, .rst_n, .table_limit(limit_reg), .cmd_valid, .cmd_ready, .cmd,
        .cmd_chars, .out_valid, .out_ready, .out_data
    );
endmodule
